// ===== hw/rtl/block_sign_magnitude_bit_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// block_sign_magnitude_bit_packer_top_defines: assertion macros
// Shared concurrent assertion forms for the bit packer.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SIGN_MAGNITUDE_BIT_PACKER_TOP_DEFINES_SVH
`define BLOCK_SIGN_MAGNITUDE_BIT_PACKER_TOP_DEFINES_SVH

// same-cycle implication
`define BSMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmp_pkg: bit packer package
// Sizes, descriptor and port structs, back-end states and width function.
// ----------------------------------------------------------------------------
package bsmp_pkg;

   localparam int BLOCK_SIZE = 32;
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 15;
   localparam int W_W        = 5;
   localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
   localparam int IDX_W      = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int ADDR_W     = IDX_W + 1;
   localparam int RAM_DEPTH  = 2 ** ADDR_W;
   localparam int ACC_W      = 32;
   localparam int BITS_W     = 5;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [W_W-1:0]    RAW_WIDTH = 5'd16;
   localparam logic [BITS_W-1:0] WORD_BITS = 5'd16;
   localparam logic [MAG_W-1:0]  MAG_MAX   = 15'h7fff;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic [W_W-1:0]   width;
   } desc_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic busy;
      logic bank;
   } back_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HEADER,
      BK_PACK,
      BK_FLUSH
   } back_state_type;

   function automatic logic [W_W-1:0] width_of(input logic [MAG_W-1:0] peak);
      logic [W_W-1:0] w;
      w = 5'd1;
      for (int i = 0; i < MAG_W; i++) begin
         if (peak[i]) begin
            w = W_W'(i + 2);
         end
      end
      return w;
   endfunction

endpackage

// ===== hw/rtl/block_sign_magnitude_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// block_sign_magnitude_bit_packer_top: block sign-magnitude bit packer
// Intake takes one sample per cycle while the two-entry block queue has room.
// The header follows a block's last sample via the queue, the HEADER state and the
// output register, with the packer idle; then at most one word per cycle, as rsp_ready allows.
// A block holds the packer for HEADER, a PACK step per sample, and FLUSH for a flush word.
// Synchronous reset clears control state; the two-bank sample RAM is not cleared.
// ----------------------------------------------------------------------------
`include "block_sign_magnitude_bit_packer_top_defines.svh"

module block_sign_magnitude_bit_packer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [bsmp_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_block_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bsmp_pkg::SAMPLE_W-1:0]        rsp_word,
   output logic                                 rsp_is_header,
   output logic                                 rsp_final_word
);

   logic                          q_full, q_push, q_pop, q_valid;
   bsmp_pkg::desc_type            push_desc, head_desc;
   bsmp_pkg::ram_wr_type          ram_wr;
   bsmp_pkg::ram_rd_type          ram_rd;
   logic [bsmp_pkg::SAMPLE_W-1:0] ram_rdata;
   bsmp_pkg::back_status_type     bk_status;

   bsmp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc),
      .ram_wr        (ram_wr)
   );

   bsmp_ram #(
      .WIDTH (bsmp_pkg::SAMPLE_W),
      .DEPTH (bsmp_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

   bsmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (push_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (head_desc)
   );

   bsmp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_desc         (head_desc),
      .q_pop          (q_pop),
      .ram_rd         (ram_rd),
      .ram_rdata      (ram_rdata),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_word       (rsp_word),
      .rsp_is_header  (rsp_is_header),
      .rsp_final_word (rsp_final_word),
      .status         (bk_status)
   );

   `BSMP_ASSERT_IMP(a_bank_conflict, clock, reset, ram_wr.en && bk_status.busy, ram_wr.addr[bsmp_pkg::ADDR_W-1] != bk_status.bank, "intake writes the bank being packed")
   `BSMP_ASSERT_IMP(a_header_word, clock, reset, rsp_valid && rsp_is_header, rsp_word >= 16'd1 && rsp_word <= 16'd16 && !rsp_final_word, "bad header word")
   `BSMP_ASSERT_IMP(a_push_room, clock, reset, q_push, !q_full, "descriptor pushed into full queue")
   `BSMP_ASSERT_NXT(a_pop_idle, clock, reset, q_pop, !bk_status.busy, "packer busy after block done")

endmodule

// ===== hw/rtl/bsmp_ram.sv =====
// ----------------------------------------------------------------------------
// bsmp_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bsmp_front.sv =====
// ----------------------------------------------------------------------------
// bsmp_front: sample intake
// Stores samples into the current RAM bank, tracks the peak magnitude and
// posts a block descriptor at the end of each block.
// ----------------------------------------------------------------------------
module bsmp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bsmp_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_block_end,
   input  logic                               q_full,
   output logic                               q_push,
   output bsmp_pkg::desc_type                 q_desc,
   output bsmp_pkg::ram_wr_type               ram_wr
);

   logic [bsmp_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [bsmp_pkg::MAG_W-1:0]    peak_ff, peak_in;
   logic                          bank_ff, bank_in;
   logic                          accept;
   logic [bsmp_pkg::SAMPLE_W-1:0] s_u, s_neg;
   logic [bsmp_pkg::MAG_W-1:0]    mag, peak_new;
   logic [bsmp_pkg::CNT_W-1:0]    count_new;
   logic                          blk_end;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   assign s_u   = $unsigned(req_sample);
   assign s_neg = ~s_u + 16'd1;

   always_comb begin
      if (s_u[bsmp_pkg::SAMPLE_W-1]) begin
         mag = s_neg[bsmp_pkg::SAMPLE_W-1] ? bsmp_pkg::MAG_MAX : s_neg[bsmp_pkg::MAG_W-1:0];
      end else begin
         mag = s_u[bsmp_pkg::MAG_W-1:0];
      end
   end

   assign peak_new  = (mag > peak_ff) ? mag : peak_ff;
   assign count_new = count_ff + 1'b1;
   assign blk_end   = req_block_end || (count_new == bsmp_pkg::CNT_W'(bsmp_pkg::BLOCK_SIZE));

   assign ram_wr.en   = accept;
   assign ram_wr.addr = {bank_ff, count_ff[bsmp_pkg::IDX_W-1:0]};
   assign ram_wr.data = s_u;

   assign q_push       = accept && blk_end;
   assign q_desc.bank  = bank_ff;
   assign q_desc.count = count_new;
   assign q_desc.width = bsmp_pkg::width_of(peak_new);

   always_comb begin
      count_in = count_ff;
      peak_in  = peak_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (blk_end) begin
            count_in = '0;
            peak_in  = '0;
            bank_in  = !bank_ff;
         end else begin
            count_in = count_new;
            peak_in  = peak_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         peak_ff  <= peak_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// ===== hw/rtl/bsmp_queue.sv =====
// ----------------------------------------------------------------------------
// bsmp_queue: block descriptor queue
// Short FIFO of finished block descriptors between intake and packer.
// ----------------------------------------------------------------------------
module bsmp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsmp_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bsmp_pkg::desc_type head_desc
);

   bsmp_pkg::desc_type             entries_ff [bsmp_pkg::Q_DEPTH];
   logic [bsmp_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bsmp_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bsmp_pkg::Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   function automatic logic [bsmp_pkg::Q_PTR_W-1:0] ptr_next(
      input logic [bsmp_pkg::Q_PTR_W-1:0] p
   );
      return (p == bsmp_pkg::Q_PTR_W'(bsmp_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (cnt_ff == bsmp_pkg::Q_CNT_W'(bsmp_pkg::Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/bsmp_back.sv =====
// ----------------------------------------------------------------------------
// bsmp_back: packer
// Emits the header, then reads the block's samples and emits raw or
// sign-magnitude packed words through an output register.
// ----------------------------------------------------------------------------
module bsmp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  bsmp_pkg::desc_type             q_desc,
   output logic                           q_pop,
   output bsmp_pkg::ram_rd_type           ram_rd,
   input  logic [bsmp_pkg::SAMPLE_W-1:0]  ram_rdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bsmp_pkg::SAMPLE_W-1:0]  rsp_word,
   output logic                           rsp_is_header,
   output logic                           rsp_final_word,
   output bsmp_pkg::back_status_type      status
);

   bsmp_pkg::back_state_type      state_ff, state_in;
   logic [bsmp_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [bsmp_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [bsmp_pkg::BITS_W-1:0]   bits_ff, bits_in;
   logic                          rsp_valid_ff;
   logic [bsmp_pkg::SAMPLE_W-1:0] rsp_word_ff;
   logic                          rsp_hdr_ff, rsp_fin_ff;

   logic                          out_free;
   logic                          emit, emit_hdr, emit_fin;
   logic [bsmp_pkg::SAMPLE_W-1:0] emit_word;

   logic                          raw;
   logic [bsmp_pkg::W_W-1:0]      w;
   logic [bsmp_pkg::SAMPLE_W-1:0] v_neg, code16, code;
   logic [bsmp_pkg::SAMPLE_W:0]   mask17;
   logic [bsmp_pkg::ACC_W-1:0]    acc_sh, acc_new;
   logic [bsmp_pkg::BITS_W-1:0]   bits_sum, bits_new;
   logic                          pk_emit, pk_done, last;
   logic [bsmp_pkg::SAMPLE_W-1:0] pk_word, flush_word;
   logic [bsmp_pkg::CNT_W-1:0]    idx_next;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign raw    = (q_desc.width == bsmp_pkg::RAW_WIDTH);
   assign w      = q_desc.width;
   assign v_neg  = ~ram_rdata + 16'd1;
   assign code16 = ram_rdata[bsmp_pkg::SAMPLE_W-1] ?
                   (v_neg | (16'd1 << (w - 5'd1))) : ram_rdata;
   assign mask17 = (17'd1 << w) - 17'd1;
   assign code   = code16 & mask17[bsmp_pkg::SAMPLE_W-1:0];
   assign acc_sh   = (acc_ff << w) | {16'd0, code};
   assign bits_sum = bits_ff + w;
   assign pk_emit  = raw || (bits_sum >= bsmp_pkg::WORD_BITS);
   assign bits_new = (pk_emit && !raw) ? bits_sum - bsmp_pkg::WORD_BITS : bits_sum;
   assign pk_word  = raw ? ram_rdata :
                     16'(acc_sh >> (bits_sum - bsmp_pkg::WORD_BITS));
   assign acc_new  = acc_sh & ((32'd1 << bits_new) - 32'd1);
   assign idx_next = idx_ff + 1'b1;
   assign last     = (idx_next == q_desc.count);
   assign pk_done  = last && (raw || (bits_new == '0));
   assign flush_word = 16'(acc_ff << (bsmp_pkg::WORD_BITS - bits_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsmp_pkg::BK_IDLE: begin
            if (q_valid) state_in = bsmp_pkg::BK_HEADER;
         end
         bsmp_pkg::BK_HEADER: begin
            if (out_free) state_in = bsmp_pkg::BK_PACK;
         end
         bsmp_pkg::BK_PACK: begin
            if (out_free && last) begin
               state_in = pk_done ? bsmp_pkg::BK_IDLE : bsmp_pkg::BK_FLUSH;
            end
         end
         bsmp_pkg::BK_FLUSH: begin
            if (out_free) state_in = bsmp_pkg::BK_IDLE;
         end
         default: state_in = bsmp_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      emit        = 1'b0;
      emit_word   = '0;
      emit_hdr    = 1'b0;
      emit_fin    = 1'b0;
      ram_rd.en   = 1'b0;
      ram_rd.addr = {q_desc.bank, bsmp_pkg::IDX_W'(0)};
      q_pop       = 1'b0;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      unique case (state_ff)
         bsmp_pkg::BK_IDLE: begin
         end
         bsmp_pkg::BK_HEADER: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = bsmp_pkg::SAMPLE_W'(w);
               emit_hdr  = 1'b1;
               ram_rd.en = 1'b1;
               idx_in    = '0;
               acc_in    = '0;
               bits_in   = '0;
            end
         end
         bsmp_pkg::BK_PACK: begin
            if (out_free) begin
               emit      = pk_emit;
               emit_word = pk_word;
               emit_fin  = pk_done;
               if (!raw) begin
                  acc_in  = acc_new;
                  bits_in = bits_new;
               end
               if (last) begin
                  q_pop = pk_done;
               end else begin
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = {q_desc.bank, idx_next[bsmp_pkg::IDX_W-1:0]};
                  idx_in      = idx_next;
               end
            end
         end
         bsmp_pkg::BK_FLUSH: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = flush_word;
               emit_fin  = 1'b1;
               q_pop     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsmp_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         acc_ff       <= '0;
         bits_ff      <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
         bits_ff  <= bits_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= emit_word;
         rsp_hdr_ff  <= emit_hdr;
         rsp_fin_ff  <= emit_fin;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_is_header  = rsp_hdr_ff;
   assign rsp_final_word = rsp_fin_ff;
   assign status.busy    = (state_ff != bsmp_pkg::BK_IDLE);
   assign status.bank    = q_desc.bank;

endmodule
